// ===== hdl/lpot_pkg.sv =====
// ----------------------------------------------------------------------------
// lpot_pkg
// Shared types and constants for the LRU page order tracker.
// ----------------------------------------------------------------------------
package lpot_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 10;
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);

   // request codes
   localparam logic REQ_TOUCH = 1'b0;
   localparam logic REQ_EVICT = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                req_type;
      logic [KEY_BITS-1:0] page_key;
   } req_item_type;

   typedef struct packed {
      logic                  hit;
      logic [1:0]            status;
      logic [KEY_BITS-1:0]   evicted_key;
      logic [KEY_BITS-1:0]   oldest_key;
      logic [COUNT_BITS-1:0] occupancy;
   } rsp_item_type;

   // broadcast to every cell
   typedef struct packed {
      logic                touch;
      logic                evict;
      logic                any_hit;
      logic [KEY_BITS-1:0] key;
   } cell_cmd_type;

endpackage

// ===== hdl/lpot_cell.sv =====
// ----------------------------------------------------------------------------
// lpot_cell
// One slot of the LRU order row: holds a key and its valid bit, compares it
// against a touched key and takes its right neighbor's key on a shift.
// ----------------------------------------------------------------------------
module lpot_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  lpot_pkg::cell_cmd_type         cmd,
   input  logic                           left_valid,
   input  logic                           left_found,
   input  logic [lpot_pkg::KEY_BITS-1:0]  right_key,
   input  logic                           right_valid,
   output logic [lpot_pkg::KEY_BITS-1:0]  key_q,
   output logic                           valid_q,
   output logic                           found_out
);

   logic [lpot_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic                          valid_ff, valid_in;
   logic                          newest;

   // found ripples toward the newest end: set at the match and beyond
   assign found_out = left_found | (cmd.touch & valid_ff & (key_ff == cmd.key));
   assign newest    = valid_ff & ~right_valid;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (cmd.touch) begin
         if (cmd.any_hit) begin
            if (newest) begin
               key_in = cmd.key;
            end else if (found_out) begin
               key_in = right_key;
            end
         end else if (~valid_ff & left_valid) begin
            // first free slot takes the new key
            key_in   = cmd.key;
            valid_in = 1'b1;
         end
      end else if (cmd.evict) begin
         key_in   = right_key;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign key_q   = key_ff;
   assign valid_q = valid_ff;

endmodule

// ===== hdl/lru_page_order_tracker.sv =====
// ----------------------------------------------------------------------------
// lru_page_order_tracker
// Keeps resident page keys ordered oldest to newest in a row of cells.
// ----------------------------------------------------------------------------
//   channel | ports                        | handshake
//   --------+------------------------------+----------------------------------
//   request | start, busy, req_item        | taken when start && !busy
//   result  | rsp_strobe, rsp_item         | one-cycle strobe, cannot stall
//
// One item per cycle: the match search ripples through the cell row and all
// cells update at the accepting edge. The result strobes in the next cycle.
// busy is always low. Synchronous reset empties the list (cell valid bits and
// count); the key registers themselves are not cleared.
// ----------------------------------------------------------------------------
module lru_page_order_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lpot_pkg::req_item_type req_item,
   output logic                   rsp_strobe,
   output lpot_pkg::rsp_item_type rsp_item
);

   localparam int N = lpot_pkg::ENTRIES;

   logic [lpot_pkg::KEY_BITS-1:0]   key_q [N];
   logic [N-1:0]                    valid_q;
   logic [N:0]                      found_chain;
   logic [N+1:0]                    valid_ext;
   logic [lpot_pkg::KEY_BITS-1:0]   key_ext [N+1];
   lpot_pkg::cell_cmd_type          cmd;

   logic                            accept, is_touch, is_evict, empty, full, any_hit;
   logic [lpot_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic                            strobe_ff, strobe_in;
   logic                            hit_ff, hit_in;
   logic [1:0]                      status_ff, status_in;
   logic [lpot_pkg::KEY_BITS-1:0]   evicted_ff, evicted_in;

   assign busy     = 1'b0;
   assign accept   = start & ~busy;
   assign is_touch = accept & (req_item.req_type == lpot_pkg::REQ_TOUCH);
   assign is_evict = accept & (req_item.req_type == lpot_pkg::REQ_EVICT);
   assign empty    = ~valid_q[0];
   assign full     = valid_q[N-1];
   assign any_hit  = found_chain[N];

   assign cmd.touch   = is_touch;
   assign cmd.evict   = is_evict & ~empty;
   assign cmd.any_hit = any_hit;
   assign cmd.key     = req_item.page_key;

   // neighbor links: a virtual always-valid slot left of cell 0, an empty
   // slot right of the last cell
   assign found_chain[0] = 1'b0;
   assign valid_ext[0]   = 1'b1;
   assign valid_ext[N+1] = 1'b0;
   assign key_ext[N]     = '0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      assign valid_ext[i+1] = valid_q[i];
      assign key_ext[i]     = key_q[i];

      lpot_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_valid  (valid_ext[i]),
         .left_found  (found_chain[i]),
         .right_key   (key_ext[i+1]),
         .right_valid (valid_ext[i+2]),
         .key_q       (key_q[i]),
         .valid_q     (valid_q[i]),
         .found_out   (found_chain[i+1])
      );
   end

   always_comb begin
      count_in   = count_ff;
      strobe_in  = accept;
      hit_in     = 1'b0;
      status_in  = lpot_pkg::STATUS_OK;
      evicted_in = '0;
      if (is_touch) begin
         if (any_hit) begin
            hit_in = 1'b1;
         end else if (full) begin
            status_in = lpot_pkg::STATUS_FULL;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else if (is_evict) begin
         if (empty) begin
            status_in = lpot_pkg::STATUS_EMPTY;
         end else begin
            evicted_in = key_q[0];
            count_in   = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff     <= hit_in;
      status_ff  <= status_in;
      evicted_ff <= evicted_in;
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // oldest key and occupancy are read from the state the item left behind
   assign rsp_strobe           = strobe_ff;
   assign rsp_item.hit         = hit_ff;
   assign rsp_item.status      = status_ff;
   assign rsp_item.evicted_key = evicted_ff;
   assign rsp_item.oldest_key  = valid_q[0] ? key_q[0] : '0;
   assign rsp_item.occupancy   = count_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the LRU page order tracker against a behavioral copy of its list.
// Directed touches and evicts cover an empty list, a full list and hits at both
// ends. Bursts of random requests then push occupancy between empty and full.
// Every result is compared field by field, in order, under several
// input idle rates.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int PHASE_ITEMS = 140;
   localparam int HOT_KEYS    = 20;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   lpot_pkg::req_item_type req_item = '0;
   logic                   rsp_strobe;
   lpot_pkg::rsp_item_type rsp_item;

   lpot_pkg::req_item_type pending_reqs[$];
   lpot_pkg::rsp_item_type expected_rsps[$];
   int                     idle_pct = 0;
   int                     mismatch_count = 0;

   // tracked list, oldest key at index 0
   logic [lpot_pkg::KEY_BITS-1:0] lru_keys [lpot_pkg::ENTRIES];
   int                            lru_count = 0;

   logic [lpot_pkg::KEY_BITS-1:0] hot_keys [HOT_KEYS];

   lru_page_order_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #5 clock = ~clock;

   function automatic lpot_pkg::rsp_item_type lru_order_step(lpot_pkg::req_item_type item);
      lpot_pkg::rsp_item_type r;
      int                     pos;
      r        = '0;
      r.status = lpot_pkg::STATUS_OK;
      pos      = -1;
      if (item.req_type == lpot_pkg::REQ_TOUCH) begin
         for (int i = 0; i < lru_count; i++)
            if (pos < 0 && lru_keys[i] == item.page_key) pos = i;
         if (pos >= 0) begin
            r.hit = 1'b1;
            for (int i = pos; i < lru_count - 1; i++) lru_keys[i] = lru_keys[i+1];
            lru_keys[lru_count-1] = item.page_key;
         end else if (lru_count < lpot_pkg::ENTRIES) begin
            lru_keys[lru_count] = item.page_key;
            lru_count++;
         end else begin
            r.status = lpot_pkg::STATUS_FULL;
         end
      end else if (lru_count == 0) begin
         r.status = lpot_pkg::STATUS_EMPTY;
      end else begin
         r.evicted_key = lru_keys[0];
         for (int i = 0; i < lru_count - 1; i++) lru_keys[i] = lru_keys[i+1];
         lru_count--;
      end
      if (lru_count > 0) r.oldest_key = lru_keys[0];
      r.occupancy = lru_count[lpot_pkg::COUNT_BITS-1:0];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) expected_rsps.push_back(lru_order_step(req_item));
         if (!(start && busy)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_item <= pending_reqs.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      lpot_pkg::rsp_item_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_item);
            mismatch_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            check_field("hit", exp_rsp.hit, rsp_item.hit);
            check_field("status", exp_rsp.status, rsp_item.status);
            check_field("evicted_key", exp_rsp.evicted_key, rsp_item.evicted_key);
            check_field("oldest_key", exp_rsp.oldest_key, rsp_item.oldest_key);
            check_field("occupancy", exp_rsp.occupancy, rsp_item.occupancy);
         end
      end
   end

   task automatic queue_touch(logic [lpot_pkg::KEY_BITS-1:0] key);
      lpot_pkg::req_item_type item;
      item.req_type = lpot_pkg::REQ_TOUCH;
      item.page_key = key;
      pending_reqs.push_back(item);
   endtask

   task automatic queue_evict();
      lpot_pkg::req_item_type item;
      item.req_type = lpot_pkg::REQ_EVICT;
      item.page_key = lpot_pkg::KEY_BITS'($urandom);
      pending_reqs.push_back(item);
   endtask

   // bursts, each with its own touch bias, so the list swings between empty and full
   task automatic queue_random_phase(int n_items);
      int sent;
      int touch_pct;
      int burst;
      sent = 0;
      for (int i = 0; i < HOT_KEYS; i++) hot_keys[i] = lpot_pkg::KEY_BITS'($urandom);
      while (sent < n_items) begin
         case ($urandom_range(2))
            0: touch_pct = 35;
            1: touch_pct = 60;
            default: touch_pct = 90;
         endcase
         burst = $urandom_range(10, 40);
         for (int i = 0; i < burst && sent < n_items; i++) begin
            if ($urandom_range(99) < touch_pct) begin
               if ($urandom_range(99) < 75)
                  queue_touch(hot_keys[$urandom_range(HOT_KEYS-1)]);
               else
                  queue_touch(lpot_pkg::KEY_BITS'($urandom));
            end else begin
               queue_evict();
            end
            sent++;
         end
      end
   endtask

   task automatic drain_pending();
      while (pending_reqs.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      // directed: empty evict, hits at both ends, emptying, full list
      queue_evict();
      queue_touch('0);
      queue_touch('1);
      queue_touch('0);
      queue_touch('0);
      queue_evict();
      queue_evict();
      queue_touch('1);
      for (int i = 0; i < lpot_pkg::ENTRIES - 1; i++)
         queue_touch(lpot_pkg::KEY_BITS'(16'h155 + 37 * i));
      queue_touch(lpot_pkg::KEY_BITS'(16'h2aa));
      queue_touch(lpot_pkg::KEY_BITS'(16'h155 + 37 * 5));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      queue_random_phase(PHASE_ITEMS);
      drain_pending();
      idle_pct <= 81;
      queue_random_phase(PHASE_ITEMS);
      drain_pending();
      idle_pct <= 26;
      queue_random_phase(PHASE_ITEMS);
      drain_pending();
      idle_pct <= 0;
      queue_random_phase(PHASE_ITEMS);

      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
